// ----- rtl/i2c_register_master_core_defines.svh -----
// Assertion macros for the I2C register master
`ifndef I2C_REGISTER_MASTER_CORE_DEFINES_SVH
`define I2C_REGISTER_MASTER_CORE_DEFINES_SVH
// Check that a condition implies a consequence in the same cycle
`define IRM_ASSERT_IMPLY(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m failed");
// Check that a condition implies a consequence in the next cycle
`define IRM_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m failed");
`endif

// ----- rtl/irm_pkg.sv -----
// ---------------------------------------------------------------------------
// irm_pkg: shared types and constants
// Phase codes, byte stages, opcodes and channel payloads.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package irm_pkg;
   localparam int FifoDepthDefault = 16;
   localparam logic [15:0] HalfPeriodReset = 16'd400;
   localparam logic [7:0]  AckTimeoutReset = 8'd250;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_LOAD  = 2'd3;

   localparam logic CSR_HALF = 1'b0;
   localparam logic CSR_ACK  = 1'b1;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_ADDR  = 2'd1;
   localparam logic [1:0] STAT_DATA  = 2'd2;

   typedef enum logic [3:0] {
      PH_IDLE, PH_RS_PREP, PH_START_HI, PH_START_LO, PH_BIT_LO, PH_BIT_HI,
      PH_ACK_LO, PH_ACK_HI, PH_ACK_POLL, PH_RD_LO, PH_RD_HI, PH_MACK_LO,
      PH_MACK_HI, PH_STOP_A, PH_STOP_B, PH_STOP_C
   } phase_type;

   typedef enum logic [2:0] {
      ST_DEV, ST_REG, ST_RADDR, ST_WDATA, ST_RDATA
   } stage_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] device_address;
      logic [7:0] register_address;
      logic [4:0] byte_count;
      logic [7:0] write_byte;
      logic       sda_sample;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_drive;
      logic       busy_res;
      logic [7:0] read_data;
      logic       read_valid;
      logic       done_res;
      logic [1:0] status;
   } rsp_type;
endpackage

// ----- rtl/irm_if.sv -----
// ---------------------------------------------------------------------------
// irm_if: valid/ready channel
// Carries one payload word between a source and a sink.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
interface irm_if #(parameter int Width = 1);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/irm_front.sv -----
// ---------------------------------------------------------------------------
// irm_front: request intake
// Accepts transactions into a two-entry queue that feeds the bus engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module irm_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  irm_pkg::req_type   in_data,
   output logic               q_valid,
   input  logic               q_ready,
   output irm_pkg::req_type   q_data
);
   irm_pkg::req_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign push = in_valid && in_ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign pop = q_valid && q_ready;
   assign q_data = mem_ff[rp_ff];
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   // store incoming transactions
   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_data;
   end

   // advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_in;
      end
   end
endmodule

// ----- rtl/irm_engine.sv -----
// ---------------------------------------------------------------------------
// irm_engine: bus phase engine
// Runs one item per cycle through the phase machine while the output queue
// has room; results are held in that two-entry output queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module irm_engine #(
   parameter int FifoDepth = irm_pkg::FifoDepthDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic             csr_index,
   input  logic [15:0]      csr_write_data,
   input  logic             q_valid,
   output logic             q_ready,
   input  irm_pkg::req_type q_data,
   output logic             out_valid,
   input  logic             out_ready,
   output irm_pkg::rsp_type out_data
);
   localparam int IdxW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
   localparam int CntW = $clog2(FifoDepth + 1);
   localparam logic [CntW-1:0] DepthC = CntW'(FifoDepth);

   logic [15:0] half_ff;
   logic [7:0]  tmo_ff;
   irm_pkg::phase_type phase_ff, phase_in;
   irm_pkg::stage_type stage_ff, stage_in;
   logic [15:0] tick_ff, tick_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [4:0]  left_ff, left_in;
   logic [7:0]  wait_ff, wait_in;
   logic [7:0]  dev_ff, dev_in, reg_ff, reg_in;
   logic [CntW-1:0] fcnt_ff, fcnt_in;
   logic [CntW-1:0] frd_ff, frd_in;
   logic        rd_ff, rd_in;
   logic [1:0]  fail_ff, fail_in;
   logic [7:0]  fifo_mem [FifoDepth];
   logic        fwe;
   logic [7:0]  fifo_q_ff;
   irm_pkg::rsp_type res;

   // result queue
   irm_pkg::rsp_type oq_ff [2];
   logic owp_ff, orp_ff;
   logic [1:0] ocnt_ff;
   logic step, opop;

   assign q_ready = (ocnt_ff != 2'd2);
   assign step = q_valid && q_ready;
   assign out_valid = (ocnt_ff != 2'd0);
   assign opop = out_valid && out_ready;
   assign out_data = oq_ff[orp_ff];

   logic [15:0] limit;
   logic        half_done;
   assign limit = (half_ff == 16'd0) ? 16'd1 : half_ff;
   assign half_done = ({1'b0, tick_ff} + 17'd1) >= {1'b0, limit};

   // next state
   always_comb begin
      logic [4:0] n;
      logic [7:0] sh;
      logic [3:0] bc;
      n = q_data.byte_count;
      sh = 8'd0;
      bc = 4'd0;
      phase_in = phase_ff; stage_in = stage_ff; tick_in = tick_ff;
      bit_in = bit_ff; shift_in = shift_ff; left_in = left_ff;
      wait_in = wait_ff; dev_in = dev_ff; reg_in = reg_ff;
      fcnt_in = fcnt_ff; frd_in = frd_ff; rd_in = rd_ff; fail_in = fail_ff;
      fwe = 1'b0;
      res = '0;
      res.scl_level = 1'b1;
      res.sda_drive = 1'b1;
      if (q_data.opcode != irm_pkg::OP_TICK) begin
         if (phase_ff == irm_pkg::PH_IDLE) begin
            if (q_data.opcode == irm_pkg::OP_LOAD) begin
               if (fcnt_ff < DepthC) begin
                  fwe = 1'b1;
                  fcnt_in = fcnt_ff + CntW'(1);
               end
            end else begin
               rd_in = (q_data.opcode == irm_pkg::OP_READ);
               if (!rd_in && (int'(n) > int'(fcnt_ff)))
                  n = 5'(fcnt_ff);
               left_in = n;
               dev_in = q_data.device_address;
               reg_in = q_data.register_address;
               frd_in = '0; fail_in = irm_pkg::STAT_OK; wait_in = 8'd0;
               shift_in = q_data.device_address;
               stage_in = irm_pkg::ST_DEV; bit_in = 4'd0; tick_in = 16'd0;
               phase_in = irm_pkg::PH_START_HI;
            end
         end
      end else begin
         if (phase_ff != irm_pkg::PH_IDLE && phase_ff != irm_pkg::PH_ACK_POLL)
            tick_in = half_done ? 16'd0 : tick_ff + 16'd1;
         case (phase_ff)
            irm_pkg::PH_RS_PREP: begin
               res.scl_level = 1'b0;
               if (half_done) phase_in = irm_pkg::PH_START_HI;
            end
            irm_pkg::PH_START_HI: if (half_done) phase_in = irm_pkg::PH_START_LO;
            irm_pkg::PH_START_LO: begin
               res.sda_drive = 1'b0;
               if (half_done) begin
                  bit_in = 4'd0; phase_in = irm_pkg::PH_BIT_LO;
               end
            end
            irm_pkg::PH_BIT_LO: begin
               res.scl_level = 1'b0; res.sda_drive = shift_ff[7];
               if (half_done) phase_in = irm_pkg::PH_BIT_HI;
            end
            irm_pkg::PH_BIT_HI: begin
               res.sda_drive = shift_ff[7];
               if (half_done) begin
                  shift_in = {shift_ff[6:0], 1'b0};
                  bit_in = bit_ff + 4'd1;
                  phase_in = (bit_in >= 4'd8) ? irm_pkg::PH_ACK_LO : irm_pkg::PH_BIT_LO;
               end
            end
            irm_pkg::PH_ACK_LO: begin
               res.scl_level = 1'b0;
               if (half_done) begin
                  wait_in = 8'd0; phase_in = irm_pkg::PH_ACK_HI;
               end
            end
            irm_pkg::PH_ACK_HI: if (half_done) phase_in = irm_pkg::PH_ACK_POLL;
            irm_pkg::PH_ACK_POLL: begin
               if (!q_data.sda_sample || wait_ff >= tmo_ff) begin
                  logic ok;
                  ok = !q_data.sda_sample;
                  tick_in = 16'd0;
                  case (stage_ff)
                     irm_pkg::ST_DEV: begin
                        if (!ok) begin
                           fail_in = irm_pkg::STAT_ADDR; phase_in = irm_pkg::PH_STOP_A;
                        end else begin
                           shift_in = reg_ff; stage_in = irm_pkg::ST_REG;
                           bit_in = 4'd0; phase_in = irm_pkg::PH_BIT_LO;
                        end
                     end
                     irm_pkg::ST_RADDR: begin
                        if (left_ff == 5'd0) phase_in = irm_pkg::PH_STOP_A;
                        else begin
                           stage_in = irm_pkg::ST_RDATA; bit_in = 4'd0;
                           shift_in = 8'd0; phase_in = irm_pkg::PH_RD_LO;
                        end
                     end
                     default: begin
                        if (stage_ff == irm_pkg::ST_REG && rd_ff) begin
                           shift_in = dev_ff + 8'd1; stage_in = irm_pkg::ST_RADDR;
                           phase_in = irm_pkg::PH_RS_PREP;
                        end else if (stage_ff != irm_pkg::ST_REG && !ok) begin
                           fail_in = irm_pkg::STAT_DATA; phase_in = irm_pkg::PH_STOP_A;
                        end else if (left_ff == 5'd0 || frd_ff >= DepthC) begin
                           phase_in = irm_pkg::PH_STOP_A;
                        end else begin
                           left_in = left_ff - 5'd1;
                           shift_in = fifo_q_ff; stage_in = irm_pkg::ST_WDATA;
                           bit_in = 4'd0; phase_in = irm_pkg::PH_BIT_LO;
                           frd_in = frd_ff + CntW'(1);
                        end
                     end
                  endcase
               end else wait_in = wait_ff + 8'd1;
            end
            irm_pkg::PH_RD_LO: begin
               res.scl_level = 1'b0;
               if (half_done) phase_in = irm_pkg::PH_RD_HI;
            end
            irm_pkg::PH_RD_HI: begin
               if (half_done) begin
                  sh = {shift_ff[6:0], q_data.sda_sample};
                  bc = bit_ff + 4'd1;
                  shift_in = sh; bit_in = bc;
                  if (bc >= 4'd8) begin
                     res.read_valid = 1'b1; res.read_data = sh;
                     if (left_ff != 5'd0) left_in = left_ff - 5'd1;
                     phase_in = irm_pkg::PH_MACK_LO;
                  end else phase_in = irm_pkg::PH_RD_LO;
               end
            end
            irm_pkg::PH_MACK_LO: begin
               res.scl_level = 1'b0; res.sda_drive = (left_ff == 5'd0);
               if (half_done) phase_in = irm_pkg::PH_MACK_HI;
            end
            irm_pkg::PH_MACK_HI: begin
               res.sda_drive = (left_ff == 5'd0);
               if (half_done) begin
                  if (left_ff == 5'd0) phase_in = irm_pkg::PH_STOP_A;
                  else begin
                     bit_in = 4'd0; shift_in = 8'd0; phase_in = irm_pkg::PH_RD_LO;
                  end
               end
            end
            irm_pkg::PH_STOP_A: begin
               res.scl_level = 1'b0; res.sda_drive = 1'b0;
               if (half_done) phase_in = irm_pkg::PH_STOP_B;
            end
            irm_pkg::PH_STOP_B: begin
               res.sda_drive = 1'b0;
               if (half_done) phase_in = irm_pkg::PH_STOP_C;
            end
            irm_pkg::PH_STOP_C: begin
               if (half_done) begin
                  res.done_res = 1'b1; res.status = fail_ff;
                  if (!rd_ff) fcnt_in = '0;
                  frd_in = '0; left_in = 5'd0; phase_in = irm_pkg::PH_IDLE;
               end
            end
            default: ;
         endcase
      end
      if (q_data.opcode != irm_pkg::OP_TICK && phase_ff == irm_pkg::PH_IDLE &&
          q_data.opcode != irm_pkg::OP_LOAD) begin
         res.scl_level = 1'b1; res.sda_drive = 1'b1;
      end
      res.busy_res = (phase_in != irm_pkg::PH_IDLE);
   end

   // write FIFO storage
   always_ff @(posedge clock) begin
      if (step && fwe) fifo_mem[fcnt_ff[IdxW-1:0]] <= q_data.write_byte;
   end

   // fetch the entry at the read index into a registered output
   always_ff @(posedge clock) begin
      fifo_q_ff <= fifo_mem[frd_ff[IdxW-1:0]];
   end

   // config and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= irm_pkg::HalfPeriodReset; tmo_ff <= irm_pkg::AckTimeoutReset;
         phase_ff <= irm_pkg::PH_IDLE; stage_ff <= irm_pkg::ST_DEV;
         tick_ff <= '0; bit_ff <= '0; shift_ff <= '0; left_ff <= '0;
         wait_ff <= '0; dev_ff <= '0; reg_ff <= '0; fcnt_ff <= '0;
         frd_ff <= '0; rd_ff <= 1'b0; fail_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == irm_pkg::CSR_HALF) half_ff <= csr_write_data;
            else tmo_ff <= csr_write_data[7:0];
         end
         if (step) begin
            phase_ff <= phase_in; stage_ff <= stage_in; tick_ff <= tick_in;
            bit_ff <= bit_in; shift_ff <= shift_in; left_ff <= left_in;
            wait_ff <= wait_in; dev_ff <= dev_in; reg_ff <= reg_in;
            fcnt_ff <= fcnt_in; frd_ff <= frd_in; rd_ff <= rd_in; fail_ff <= fail_in;
         end
      end
   end

   // result queue storage
   always_ff @(posedge clock) begin
      if (step) oq_ff[owp_ff] <= res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owp_ff <= 1'b0; orp_ff <= 1'b0; ocnt_ff <= 2'd0;
      end else begin
         if (step) owp_ff <= ~owp_ff;
         if (opop) orp_ff <= ~orp_ff;
         ocnt_ff <= ocnt_ff + {1'b0, step} - {1'b0, opop};
      end
   end
endmodule

// ----- rtl/i2c_register_master_core.sv -----
// A transaction's result passes through the intake queue, then the phase
// engine writes it into the result queue.
// Throughput: one transaction per cycle while the result queue has room.
// Bus timing scales with the CSR_HALF half-period register; all timing counts tick items.
// Reset: synchronous, active high; clears queues, phase and counters and
// loads the register reset values; the write FIFO contents are not cleared.
`timescale 1ns / 1ps
`include "i2c_register_master_core_defines.svh"
module i2c_register_master_core #(
   parameter int FifoDepth = irm_pkg::FifoDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   irm_if.sink         req_ch,
   irm_if.source       rsp_ch,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data
);
   logic q_valid, q_ready;
   irm_pkg::req_type q_data;
   irm_pkg::rsp_type rsp_data;

   irm_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_ch.valid), .in_ready(req_ch.ready), .in_data(req_ch.data),
      .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
   );

   irm_engine #(.FifoDepth(FifoDepth)) u_engine (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
      .out_valid(rsp_ch.valid), .out_ready(rsp_ch.ready), .out_data(rsp_data)
   );
   assign rsp_ch.data = rsp_data;

   // done results carry a busy flag of zero
   `IRM_ASSERT_IMPLY(a_done_idle, clock, reset,
      rsp_ch.valid && rsp_data.done_res, !rsp_data.busy_res)
   // status only reported with done
   `IRM_ASSERT_IMPLY(a_stat_done, clock, reset,
      rsp_ch.valid && !rsp_data.done_res, rsp_data.status == irm_pkg::STAT_OK)
   // read byte never coincides with bus completion
   `IRM_ASSERT_IMPLY(a_rd_not_done, clock, reset,
      rsp_ch.valid && rsp_data.read_valid, !rsp_data.done_res)
endmodule

// ----- tb/tb_i2c_register_master_core.sv -----
// ---------------------------------------------------------------------------
// tb_i2c_register_master_core: tick-level check of the I2C register master
// Drives tick, load and start commands, predicts the bus levels, read bytes
// and completion status of every accepted item, and compares each response.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_i2c_register_master_core;
   localparam int Depth = irm_pkg::FifoDepthDefault;
   localparam int QuietLimit = 4000;

   // Predicts the bus master tick by tick and holds the expected responses
   class i2c_transfer_checker;
      logic [15:0] half_ticks;
      logic [7:0]  ack_limit;
      irm_pkg::phase_type phase;
      irm_pkg::stage_type stage;
      int          tick_cnt, bit_cnt, bytes_left, ack_wait, fifo_cnt, fifo_rd;
      logic [7:0]  shift_byte, dev_addr, reg_addr;
      logic [7:0]  wr_fifo[Depth];
      logic        is_read;
      logic [1:0]  fail_code;
      irm_pkg::rsp_type expected_levels[$];
      int          mismatches;
      int          checked;
      int          reads_seen;
      int          done_seen[3];

      function new();
         half_ticks = irm_pkg::HalfPeriodReset;
         ack_limit = irm_pkg::AckTimeoutReset;
         phase = irm_pkg::PH_IDLE;
         stage = irm_pkg::ST_DEV;
         tick_cnt = 0; bit_cnt = 0; bytes_left = 0; ack_wait = 0;
         fifo_cnt = 0; fifo_rd = 0;
         shift_byte = '0; dev_addr = '0; reg_addr = '0;
         is_read = 1'b0; fail_code = irm_pkg::STAT_OK;
         mismatches = 0; checked = 0; reads_seen = 0;
         done_seen = '{0, 0, 0};
      endfunction

      function void write_reg(logic idx, logic [15:0] v);
         if (idx == irm_pkg::CSR_HALF) half_ticks = v;
         else ack_limit = v[7:0];
      endfunction

      function bit half_elapsed();
         int lim;
         lim = (half_ticks == 0) ? 1 : int'(half_ticks);
         if (tick_cnt + 1 >= lim) begin
            tick_cnt = 0;
            return 1'b1;
         end
         tick_cnt++;
         return 1'b0;
      endfunction

      function void go_send(logic [7:0] b, irm_pkg::stage_type st);
         shift_byte = b;
         stage = st;
         bit_cnt = 0;
         tick_cnt = 0;
         phase = irm_pkg::PH_BIT_LO;
      endfunction

      function void go_stop();
         tick_cnt = 0;
         phase = irm_pkg::PH_STOP_A;
      endfunction

      function void next_write();
         if (bytes_left == 0 || fifo_rd >= Depth) begin
            go_stop();
            return;
         end
         bytes_left--;
         go_send(wr_fifo[fifo_rd], irm_pkg::ST_WDATA);
         fifo_rd++;
      endfunction

      function void after_ack(bit ok);
         tick_cnt = 0;
         case (stage)
            irm_pkg::ST_DEV: begin
               if (!ok) begin
                  fail_code = irm_pkg::STAT_ADDR;
                  go_stop();
               end else go_send(reg_addr, irm_pkg::ST_REG);
            end
            irm_pkg::ST_REG: begin
               if (is_read) begin
                  shift_byte = dev_addr + 8'd1;
                  stage = irm_pkg::ST_RADDR;
                  phase = irm_pkg::PH_RS_PREP;
               end else next_write();
            end
            irm_pkg::ST_RADDR: begin
               if (bytes_left == 0) go_stop();
               else begin
                  stage = irm_pkg::ST_RDATA;
                  bit_cnt = 0;
                  shift_byte = '0;
                  phase = irm_pkg::PH_RD_LO;
               end
            end
            default: begin
               if (!ok) begin
                  fail_code = irm_pkg::STAT_DATA;
                  go_stop();
               end else next_write();
            end
         endcase
      endfunction

      // Advance the predicted master by one accepted item
      function irm_pkg::rsp_type predict_tick(irm_pkg::req_type r);
         irm_pkg::rsp_type o;
         int n;
         o = '0;
         o.scl_level = 1'b1;
         o.sda_drive = 1'b1;
         if (r.opcode != irm_pkg::OP_TICK) begin
            if (phase == irm_pkg::PH_IDLE) begin
               if (r.opcode == irm_pkg::OP_LOAD) begin
                  if (fifo_cnt < Depth) begin
                     wr_fifo[fifo_cnt] = r.write_byte;
                     fifo_cnt++;
                  end
               end else begin
                  n = r.byte_count;
                  is_read = (r.opcode == irm_pkg::OP_READ);
                  if (!is_read && n > fifo_cnt) n = fifo_cnt;
                  bytes_left = n;
                  dev_addr = r.device_address;
                  reg_addr = r.register_address;
                  fifo_rd = 0;
                  fail_code = irm_pkg::STAT_OK;
                  ack_wait = 0;
                  shift_byte = dev_addr;
                  stage = irm_pkg::ST_DEV;
                  bit_cnt = 0;
                  tick_cnt = 0;
                  phase = irm_pkg::PH_START_HI;
               end
            end
         end else begin
            case (phase)
               irm_pkg::PH_RS_PREP: begin
                  o.scl_level = 1'b0;
                  if (half_elapsed()) phase = irm_pkg::PH_START_HI;
               end
               irm_pkg::PH_START_HI: if (half_elapsed()) phase = irm_pkg::PH_START_LO;
               irm_pkg::PH_START_LO: begin
                  o.sda_drive = 1'b0;
                  if (half_elapsed()) begin
                     bit_cnt = 0;
                     phase = irm_pkg::PH_BIT_LO;
                  end
               end
               irm_pkg::PH_BIT_LO: begin
                  o.scl_level = 1'b0;
                  o.sda_drive = shift_byte[7];
                  if (half_elapsed()) phase = irm_pkg::PH_BIT_HI;
               end
               irm_pkg::PH_BIT_HI: begin
                  o.sda_drive = shift_byte[7];
                  if (half_elapsed()) begin
                     shift_byte = shift_byte << 1;
                     bit_cnt++;
                     phase = (bit_cnt >= 8) ? irm_pkg::PH_ACK_LO : irm_pkg::PH_BIT_LO;
                  end
               end
               irm_pkg::PH_ACK_LO: begin
                  o.scl_level = 1'b0;
                  if (half_elapsed()) begin
                     ack_wait = 0;
                     phase = irm_pkg::PH_ACK_HI;
                  end
               end
               irm_pkg::PH_ACK_HI: if (half_elapsed()) phase = irm_pkg::PH_ACK_POLL;
               irm_pkg::PH_ACK_POLL: begin
                  if (r.sda_sample == 1'b0) after_ack(1'b1);
                  else if (ack_wait >= int'(ack_limit)) after_ack(1'b0);
                  else ack_wait++;
               end
               irm_pkg::PH_RD_LO: begin
                  o.scl_level = 1'b0;
                  if (half_elapsed()) phase = irm_pkg::PH_RD_HI;
               end
               irm_pkg::PH_RD_HI: begin
                  if (half_elapsed()) begin
                     shift_byte = {shift_byte[6:0], r.sda_sample};
                     bit_cnt++;
                     if (bit_cnt >= 8) begin
                        o.read_valid = 1'b1;
                        o.read_data = shift_byte;
                        if (bytes_left != 0) bytes_left--;
                        phase = irm_pkg::PH_MACK_LO;
                     end else phase = irm_pkg::PH_RD_LO;
                  end
               end
               irm_pkg::PH_MACK_LO: begin
                  o.scl_level = 1'b0;
                  o.sda_drive = (bytes_left == 0);
                  if (half_elapsed()) phase = irm_pkg::PH_MACK_HI;
               end
               irm_pkg::PH_MACK_HI: begin
                  o.sda_drive = (bytes_left == 0);
                  if (half_elapsed()) begin
                     if (bytes_left == 0) go_stop();
                     else begin
                        bit_cnt = 0;
                        shift_byte = '0;
                        phase = irm_pkg::PH_RD_LO;
                     end
                  end
               end
               irm_pkg::PH_STOP_A: begin
                  o.scl_level = 1'b0;
                  o.sda_drive = 1'b0;
                  if (half_elapsed()) phase = irm_pkg::PH_STOP_B;
               end
               irm_pkg::PH_STOP_B: begin
                  o.sda_drive = 1'b0;
                  if (half_elapsed()) phase = irm_pkg::PH_STOP_C;
               end
               irm_pkg::PH_STOP_C: begin
                  if (half_elapsed()) begin
                     o.done_res = 1'b1;
                     o.status = fail_code;
                     if (!is_read) fifo_cnt = 0;
                     fifo_rd = 0;
                     bytes_left = 0;
                     phase = irm_pkg::PH_IDLE;
                  end
               end
               default: ;
            endcase
         end
         o.busy_res = (phase != irm_pkg::PH_IDLE);
         return o;
      endfunction

      function void note_request(irm_pkg::req_type r);
         expected_levels.push_back(predict_tick(r));
      endfunction

      task report(string what, int want, int got);
         $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
         mismatches++;
      endtask

      task check_response(irm_pkg::rsp_type got);
         irm_pkg::rsp_type want;
         if (expected_levels.size() == 0) begin
            report("unexpected response, count", 0, 1);
            return;
         end
         want = expected_levels.pop_front();
         checked++;
         if (want.read_valid) reads_seen++;
         if (want.done_res) done_seen[want.status]++;
         if (got.scl_level !== want.scl_level) report("scl_level", want.scl_level, got.scl_level);
         if (got.sda_drive !== want.sda_drive) report("sda_drive", want.sda_drive, got.sda_drive);
         if (got.busy_res !== want.busy_res) report("busy_res", want.busy_res, got.busy_res);
         if (got.read_data !== want.read_data) report("read_data", want.read_data, got.read_data);
         if (got.read_valid !== want.read_valid)
            report("read_valid", want.read_valid, got.read_valid);
         if (got.done_res !== want.done_res) report("done_res", want.done_res, got.done_res);
         if (got.status !== want.status) report("status", want.status, got.status);
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic        csr_index;
   logic [15:0] csr_write_data;

   irm_if #(.Width($bits(irm_pkg::req_type))) req_ch ();
   irm_if #(.Width($bits(irm_pkg::rsp_type))) rsp_ch ();

   i2c_register_master_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch.sink),
      .rsp_ch           (rsp_ch.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   i2c_transfer_checker checker_h = new();
   int  gap_pct = 0;
   int  stall_pct = 0;
   int  hold_cycles = 0;
   bit  hold_request = 1'b0;
   int  items_sent = 0;
   int  quiet_cycles = 0;

   // Clock
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Response side: check each transaction, then pick next ready
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) checker_h.check_response(rsp_ch.data);
      if (hold_request) begin
         hold_cycles = 120;
         hold_request = 1'b0;
      end
      if (reset) rsp_ch.ready <= 1'b0;
      else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_ch.ready <= 1'b0;
      end else rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Watchdog on stretches without any accepted transaction
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
         $display("watchdog expired with %0d responses pending",
                  checker_h.expected_levels.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Offer one item, with random gaps ahead of it, and note it on acceptance
   task automatic send_item(irm_pkg::req_type r);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      checker_h.note_request(r);
      items_sent++;
   endtask

   task automatic send_op(logic [1:0] op, logic [7:0] dev, logic [7:0] regi,
                          logic [4:0] cnt, logic [7:0] wb, logic sda);
      irm_pkg::req_type r;
      r.opcode = op;
      r.device_address = dev;
      r.register_address = regi;
      r.byte_count = cnt;
      r.write_byte = wb;
      r.sda_sample = sda;
      send_item(r);
   endtask

   // Tick until the transfer ends, mixing in random other commands; NACK the ACK slot of one byte stage
   task automatic run_transfer(int low_pct, irm_pkg::stage_type nack_stage, int noise_pct);
      logic sda;
      while (checker_h.phase != irm_pkg::PH_IDLE) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            send_op(2'($urandom_range(1, 3)), 8'($urandom), 8'($urandom),
                    5'($urandom), 8'($urandom), 1'($urandom));
         end else begin
            if (checker_h.phase == irm_pkg::PH_ACK_POLL && checker_h.stage == nack_stage)
               sda = 1'b1;
            else sda = ($urandom_range(0, 99) >= low_pct);
            send_op(irm_pkg::OP_TICK, 8'($urandom), 8'($urandom), 5'($urandom),
                    8'($urandom), sda);
         end
      end
   endtask

   // Drop valid and wait until all responses are in
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (checker_h.expected_levels.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [15:0] v);
      drain();
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      checker_h.write_reg(idx, v);
   endtask

   task automatic load_bytes(int k);
      for (int i = 0; i < k; i++)
         send_op(irm_pkg::OP_LOAD, 8'($urandom), 8'($urandom), 5'($urandom),
                 8'($urandom), 1'($urandom));
   endtask

   initial begin
      int target;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      csr_write_enable = 1'b0;
      csr_index = irm_pkg::CSR_HALF;
      csr_write_data = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, fast bus
      write_csr(irm_pkg::CSR_HALF, 16'd1);
      write_csr(irm_pkg::CSR_ACK, 16'd2);
      // full FIFO with one load too many, then a short write
      send_op(irm_pkg::OP_LOAD, 8'h00, 8'h00, 5'd0, 8'h00, 1'b0);
      send_op(irm_pkg::OP_LOAD, 8'hFF, 8'hFF, 5'd31, 8'hFF, 1'b1);
      load_bytes(Depth - 1);
      send_op(irm_pkg::OP_WRITE, 8'hFF, 8'h00, 5'd2, 8'h5A, 1'b0);
      // commands while busy are ignored
      send_op(irm_pkg::OP_LOAD, 8'h12, 8'h34, 5'd3, 8'hC3, 1'b0);
      send_op(irm_pkg::OP_READ, 8'h12, 8'h34, 5'd3, 8'hC3, 1'b0);
      run_transfer(100, irm_pkg::ST_RDATA, 0);
      // address not acknowledged
      send_op(irm_pkg::OP_WRITE, 8'h00, 8'hFF, 5'd0, 8'h00, 1'b1);
      run_transfer(0, irm_pkg::ST_RDATA, 0);
      // data not acknowledged, count beyond FIFO fill
      send_op(irm_pkg::OP_LOAD, 8'h00, 8'h00, 5'd0, 8'hA5, 1'b0);
      send_op(irm_pkg::OP_LOAD, 8'h00, 8'h00, 5'd0, 8'h3C, 1'b0);
      send_op(irm_pkg::OP_WRITE, 8'hA0, 8'h10, 5'd16, 8'h00, 1'b0);
      run_transfer(100, irm_pkg::ST_WDATA, 0);
      // zero write count with loaded bytes
      load_bytes(2);
      send_op(irm_pkg::OP_WRITE, 8'h42, 8'h81, 5'd0, 8'h00, 1'b0);
      run_transfer(100, irm_pkg::ST_RDATA, 0);
      // zero half period and zero timeout, zero read count
      write_csr(irm_pkg::CSR_HALF, 16'd0);
      write_csr(irm_pkg::CSR_ACK, 16'd0);
      send_op(irm_pkg::OP_READ, 8'hFF, 8'h7E, 5'd0, 8'h00, 1'b0);
      run_transfer(50, irm_pkg::ST_RDATA, 0);
      // widest half period: a few ticks into the start, then a fast finish
      write_csr(irm_pkg::CSR_HALF, 16'hFFFF);
      load_bytes(2);
      send_op(irm_pkg::OP_TICK, 8'h00, 8'h00, 5'd0, 8'h00, 1'b1);
      send_op(irm_pkg::OP_WRITE, 8'h20, 8'h01, 5'd2, 8'h00, 1'b0);
      send_op(irm_pkg::OP_TICK, 8'h00, 8'h00, 5'd0, 8'h00, 1'b0);
      send_op(irm_pkg::OP_TICK, 8'h00, 8'h00, 5'd0, 8'h00, 1'b0);
      drain();
      write_csr(irm_pkg::CSR_HALF, 16'd1);
      run_transfer(100, irm_pkg::ST_DEV, 0);

      // Random part in four phases with different gap and stall settings
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 53; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 53; end
            default: begin gap_pct = 32; stall_pct = 32; end
         endcase
         write_csr(irm_pkg::CSR_HALF, 16'($urandom_range(0, 2)));
         write_csr(irm_pkg::CSR_ACK, 16'($urandom_range(0, 6)));
         if (ph == 0) hold_request = 1'b1;
         target = items_sent + 25;
         while (items_sent < target) begin
            load_bytes($urandom_range(0, 4));
            if ($urandom_range(0, 9) == 0)
               send_op(irm_pkg::OP_TICK, 8'($urandom), 8'($urandom), 5'($urandom),
                       8'($urandom), 1'($urandom));
            send_op($urandom_range(0, 1) ? irm_pkg::OP_READ : irm_pkg::OP_WRITE,
                    8'($urandom), 8'($urandom),
                    ($urandom_range(0, 19) == 0) ? 5'($urandom_range(4, 31))
                                                 : 5'($urandom_range(0, 3)),
                    8'($urandom), 1'($urandom));
            case ($urandom_range(0, 5))
               0: run_transfer(50, irm_pkg::ST_RDATA, 3);
               1: run_transfer(95, irm_pkg::ST_DEV, 3);
               2: run_transfer(95, irm_pkg::ST_WDATA, 3);
               default: run_transfer(($urandom_range(0, 1) ? 60 : 90), irm_pkg::ST_RDATA, 3);
            endcase
         end
      end

      drain();
      repeat (20) @(posedge clock);
      $display("%0d items driven, %0d responses checked, %0d read bytes",
               items_sent, checker_h.checked, checker_h.reads_seen);
      $display("transfers ended ok %0d, address NACK %0d, data NACK %0d",
               checker_h.done_seen[0], checker_h.done_seen[1], checker_h.done_seen[2]);
      if (checker_h.mismatches == 0 && checker_h.expected_levels.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
